// ===== rtl/core/esd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    // One input word: a raw character and the end-of-string flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_string;
    } t_in;

    // One result word: a decoded character or a token end marker.
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] term;
    } t_out;

    localparam logic [1:0] TERM_CHAR = 2'd0;
    localparam logic [1:0] TERM_STOP = 2'd1;
    localparam logic [1:0] TERM_EOS  = 2'd2;

    localparam logic [7:0] CARET_CHAR   = 8'h5E;
    localparam logic [7:0] BSLASH_CHAR  = 8'h5C;
    localparam logic [7:0] CARET_OFFSET = 8'o100;
    localparam logic [7:0] STOP_RESET   = 8'd32;

    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    // Backslash letter escapes; anything else stands for itself.
    function automatic logic [7:0] escape_of(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            8'h6E:   v = 8'h0A;
            8'h72:   v = 8'h0D;
            8'h74:   v = 8'h09;
            8'h62:   v = 8'h08;
            8'h66:   v = 8'h0C;
            default: v = c;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/escape_sequence_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result words of an accepted input word are queued and leave in order on o_out_data.
// Throughput: one input word per cycle while the queue has room; each yields zero to
// three result words, drained from an eight-entry result queue one per cycle while
// i_out_ready is high, so the sustained rate is set by the single output port.
// Reset (synchronous, i_rst_n low): mode to normal, octal value to zero, stop character
// to 32 (space), result queue emptied.

module escape_sequence_decoder_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  esd_pkg::t_in         i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output esd_pkg::t_out        o_out_data,
    // stop character register
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [7:0]            i_cfg_data
);
    import esd_pkg::*;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_CARET  = 3'd1,
        M_BSLASH = 3'd2,
        M_OCT1   = 3'd3,
        M_OCT2   = 3'd4
    } t_mode;

    t_mode                r_mode;
    t_mode                n_mode;
    logic [8:0]           r_octal;
    logic [8:0]           n_octal;
    logic [7:0]           r_stop_char;

    // result queue
    t_out                 r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;

    // decode outputs
    t_out                 res [MAX_RES];
    logic [1:0]           n_push;

    logic                 in_fire;
    logic                 out_fire;

    // Accept only while the queue has room for the worst case of one word.
    assign o_in_ready  = (r_count <= FIFO_CW'(FIFO_DEPTH - MAX_RES));
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_out_data  = r_fifo[r_rd];
    assign o_cfg_ready = 1'b1;

    // Decode one character against the current mode. Results are appended in order;
    // at most three: a pending octal value, the character itself, then the string end.
    always_comb begin
        logic [7:0] c;
        logic       eos;
        logic [8:0] acc;
        logic       run_normal;
        c          = i_in_data.ch;
        eos        = i_in_data.end_of_string;
        acc        = {r_octal[5:0], c[2:0]};
        run_normal = 1'b0;
        n_push     = 2'd0;
        n_mode     = M_NORMAL;
        n_octal    = r_octal;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '{out_char: 8'h00, term: TERM_CHAR};
        end

        case (r_mode)
            M_CARET: begin
                res[n_push] = '{out_char: c - CARET_OFFSET, term: TERM_CHAR};
                n_push      = n_push + 2'd1;
            end
            M_BSLASH: begin
                if (is_octal(c)) begin
                    n_octal = {6'd0, c[2:0]};
                    if (eos) begin
                        res[n_push] = '{out_char: {5'd0, c[2:0]}, term: TERM_CHAR};
                        n_push      = n_push + 2'd1;
                    end else begin
                        n_mode = M_OCT1;
                    end
                end else begin
                    res[n_push] = '{out_char: escape_of(c), term: TERM_CHAR};
                    n_push      = n_push + 2'd1;
                end
            end
            M_OCT1, M_OCT2: begin
                if (is_octal(c)) begin
                    n_octal = acc;
                    if (eos || (r_mode == M_OCT2)) begin
                        res[n_push] = '{out_char: acc[7:0], term: TERM_CHAR};
                        n_push      = n_push + 2'd1;
                    end else begin
                        n_mode = M_OCT2;
                    end
                end else begin
                    // Flush the cut-short octal run, then treat the character as normal.
                    res[n_push] = '{out_char: r_octal[7:0], term: TERM_CHAR};
                    n_push      = n_push + 2'd1;
                    run_normal  = 1'b1;
                end
            end
            default: begin
                run_normal = 1'b1;
            end
        endcase

        if (run_normal) begin
            if (c == r_stop_char) begin
                res[n_push] = '{out_char: 8'h00, term: TERM_STOP};
                n_push      = n_push + 2'd1;
            end else if (c == CARET_CHAR) begin
                // A caret at the string end stands for itself.
                if (eos) begin
                    res[n_push] = '{out_char: c, term: TERM_CHAR};
                    n_push      = n_push + 2'd1;
                end else begin
                    n_mode = M_CARET;
                end
            end else if (c == BSLASH_CHAR) begin
                // Drop a lone backslash at the string end.
                if (!eos) begin
                    n_mode = M_BSLASH;
                end
            end else begin
                res[n_push] = '{out_char: c, term: TERM_CHAR};
                n_push      = n_push + 2'd1;
            end
        end

        if (eos) begin
            res[n_push] = '{out_char: 8'h00, term: TERM_EOS};
            n_push      = n_push + 2'd1;
            n_mode      = M_NORMAL;
        end
    end

    // Decoder state and the stop character register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NORMAL;
            r_octal     <= '0;
            r_stop_char <= STOP_RESET;
        end else begin
            if (in_fire) begin
                r_mode  <= n_mode;
                r_octal <= n_octal;
            end
            if (i_cfg_valid) begin
                r_stop_char <= i_cfg_data;
            end
        end
    end

    // Queue pointers and fill count: push up to three, pop one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (in_fire) begin
                r_wr <= r_wr + FIFO_AW'(n_push);
            end
            if (out_fire) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_count <= r_count + (in_fire ? FIFO_CW'(n_push) : FIFO_CW'(0))
                               - (out_fire ? FIFO_CW'(1) : FIFO_CW'(0));
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (in_fire && (k < int'(n_push))) begin
                r_fifo[r_wr + FIFO_AW'(k)] <= res[k];
            end
        end
    end

endmodule

`default_nettype wire
